/* src/efsa_pkg.sv */
// ----------------------------------------------------------------------------
// efsa_pkg
// Shared types and constants for the embedded free-list slot allocator.
// ----------------------------------------------------------------------------
package efsa_pkg;

    // Number of slots in the pool, and the field widths that follow from it.
    localparam int SLOTS  = 255;
    localparam int SLOT_W = 8;
    localparam int OBJ_W  = 16;
    localparam int OFF_W  = 24;

    // Pool size one bit wider than a slot index, for range compares.
    localparam logic [SLOT_W:0] SLOTS_X = (SLOT_W + 1)'(SLOTS);

    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CHECK   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_FULL    = 3'd1,
        STS_RANGE   = 3'd2,
        STS_DOUBLE  = 3'd3,
        STS_CORRUPT = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC,
        S_CHECK,
        S_UNDO
    } t_state;

    // One access to the link store: an optional write and an
    // optional read, each at its own address. An entry holds a link and a
    // visited mark that is only set during an integrity walk.
    typedef struct packed {
        logic  wr;
        logic  rd;
        t_slot waddr;
        t_slot raddr;
        t_slot wdata;
        logic  wmark;
    } t_link_req;

endpackage

/* src/efsa_ram.sv */
// ----------------------------------------------------------------------------
// efsa_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module efsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/efsa_link_store.sv */
// ----------------------------------------------------------------------------
// efsa_link_store
// Next-link store of the free list. A RAM holds each link with a visited
// mark; a written flag per entry makes an entry that was never written read
// as its index plus one with the mark clear.
// ----------------------------------------------------------------------------
module efsa_link_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  efsa_pkg::t_link_req  i_req,
    output efsa_pkg::t_slot      o_link,
    output logic                 o_mark
);

    logic [efsa_pkg::SLOTS-1:0]  r_written;
    efsa_pkg::t_slot             r_raddr;
    logic                        r_byp;
    logic [efsa_pkg::SLOT_W:0]   r_byp_data;
    logic [efsa_pkg::SLOT_W:0]   ram_q;

    efsa_ram #(
        .WIDTH (efsa_pkg::SLOT_W + 1),
        .DEPTH (efsa_pkg::SLOTS),
        .AW    (efsa_pkg::SLOT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.wr),
        .i_waddr (i_req.waddr),
        .i_wdata ({i_req.wmark, i_req.wdata}),
        .i_re    (i_req.rd),
        .i_raddr (i_req.raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_req.wr) begin
            r_written[i_req.waddr] <= 1'b1;
        end
    end

    // A read of the entry being written in the same cycle returns the new
    // contents.
    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_raddr    <= i_req.raddr;
            r_byp      <= i_req.wr && (i_req.waddr == i_req.raddr);
            r_byp_data <= {i_req.wmark, i_req.wdata};
        end
    end

    // An entry still at its reset value links to the next slot, unmarked.
    always_comb begin
        if (r_byp) begin
            {o_mark, o_link} = r_byp_data;
        end else if (r_written[r_raddr]) begin
            {o_mark, o_link} = ram_q;
        end else begin
            o_mark = 1'b0;
            o_link = efsa_pkg::t_slot'(r_raddr + 1'b1);
        end
    end

endmodule

/* src/embedded_free_list_slot_allocator_top.sv */
// ----------------------------------------------------------------------------
// embedded_free_list_slot_allocator_top
// Fixed pool of equal slots whose free list lives as a next-index link in
// each free slot; allocate, release and list-integrity check.
// ----------------------------------------------------------------------------
// Usage:
// An item is taken at a rising edge where start is high and busy is low; its
// fields are i_op (allocate, release, check) and i_slot (the slot to release).
// Every item yields one result, shown for a single cycle with o_done high on
// o_status, o_granted_slot, o_byte_offset and o_free_count. The receiver has
// no way to stall, so it must take the result in that cycle.
// A release, a rejected item, an ignored op and a check that needs no walk
// show their result in the cycle after the item is taken with busy low.
// A successful allocate reads the head's link from the link RAM (registered
// read), so busy is high in state S_ALLOC and the result shows as busy
// falls.
// A check with N free slots (N at least two) marks every slot it visits in the
// link RAM, one link per cycle, then walks the marked slots again to clear the
// marks. The result shows as busy falls; a loop or a bad link cuts the walk
// short.
// The user writes the object size register (i_cfg_we, i_cfg_wdata) only while idle;
// the block does not enforce it. Reset (synchronous, active low) puts the head at
// slot 0 and counts every slot free; per-entry written flags make each link read as
// its index plus one, so no clearing pass is needed and the block is ready at once.
// ----------------------------------------------------------------------------
module embedded_free_list_slot_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_slot,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [7:0]  o_granted_slot,
    output logic [23:0] o_byte_offset,
    output logic [7:0]  o_free_count
);

    // Control state.
    efsa_pkg::t_state r_state, n_state;
    efsa_pkg::t_slot  r_head, n_head;
    efsa_pkg::t_slot  r_free, n_free;
    efsa_pkg::t_slot  r_cnt, n_cnt;
    efsa_pkg::t_slot  r_idx, n_idx;
    logic [efsa_pkg::OBJ_W-1:0] r_obj_size;

    // Offset of the slot being allocated, formed while its link is read.
    logic [efsa_pkg::OFF_W-1:0] r_offset, n_offset;

    // Outcome of the integrity walk, held while its marks are cleared.
    efsa_pkg::t_status          r_chk_sts, n_chk_sts;

    // Registered result.
    logic                       r_done, n_done;
    efsa_pkg::t_status          r_status, n_status;
    efsa_pkg::t_slot            r_gslot, n_gslot;
    logic [efsa_pkg::OFF_W-1:0] r_res_off, n_res_off;
    efsa_pkg::t_slot            r_res_free, n_res_free;

    efsa_pkg::t_link_req link_req;
    efsa_pkg::t_slot     link_q;
    logic                link_mark;

    logic head_in_pool;
    logic slot_in_pool;
    logic link_in_pool;
    logic walk_last;

    efsa_link_store u_links (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (link_req),
        .o_link  (link_q),
        .o_mark  (link_mark)
    );

    assign head_in_pool = {1'b0, r_head} < efsa_pkg::SLOTS_X;
    assign slot_in_pool = {1'b0, i_slot} < efsa_pkg::SLOTS_X;
    assign link_in_pool = {1'b0, link_q} < efsa_pkg::SLOTS_X;
    // The walk ends once the slot being marked brings the count of marked
    // slots to the free count.
    assign walk_last    = ({1'b0, r_cnt} + 1'b1) >= {1'b0, r_free};

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_free     = r_free;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_offset   = r_offset;
        n_chk_sts  = r_chk_sts;
        n_done     = 1'b0;
        n_status   = efsa_pkg::STS_OK;
        n_gslot    = '0;
        n_res_off  = '0;
        n_res_free = r_free;
        link_req   = '{wr: 1'b0, rd: 1'b0, waddr: r_idx, raddr: r_head,
                       wdata: r_head, wmark: 1'b0};

        case (r_state)
            efsa_pkg::S_IDLE: begin
                if (start) begin
                    case (efsa_pkg::t_op'(i_op))
                        efsa_pkg::OP_ALLOC: begin
                            if (r_free == '0) begin
                                n_done   = 1'b1;
                                n_status = efsa_pkg::STS_FULL;
                            end else if (!head_in_pool) begin
                                n_done   = 1'b1;
                                n_status = efsa_pkg::STS_CORRUPT;
                            end else begin
                                link_req.rd = 1'b1;
                                n_idx       = r_head;
                                n_offset    = efsa_pkg::OFF_W'(r_head) *
                                              efsa_pkg::OFF_W'(r_obj_size);
                                n_state     = efsa_pkg::S_ALLOC;
                            end
                        end
                        efsa_pkg::OP_RELEASE: begin
                            n_done = 1'b1;
                            if (!slot_in_pool) begin
                                n_status = efsa_pkg::STS_RANGE;
                            end else if ({1'b0, r_free} >= efsa_pkg::SLOTS_X) begin
                                n_status = efsa_pkg::STS_DOUBLE;
                            end else if (r_free != '0 && i_slot == r_head) begin
                                n_status = efsa_pkg::STS_DOUBLE;
                            end else begin
                                link_req.wr    = 1'b1;
                                link_req.waddr = i_slot;
                                n_head         = i_slot;
                                n_free         = r_free + 1'b1;
                                n_res_free     = r_free + 1'b1;
                            end
                        end
                        efsa_pkg::OP_CHECK: begin
                            if (r_free == '0) begin
                                n_done = 1'b1;
                            end else if (!head_in_pool) begin
                                n_done   = 1'b1;
                                n_status = efsa_pkg::STS_CORRUPT;
                            end else if (r_free == efsa_pkg::t_slot'(1)) begin
                                // The head alone makes up the list.
                                n_done = 1'b1;
                            end else begin
                                link_req.rd = 1'b1;
                                n_idx       = r_head;
                                n_cnt       = '0;
                                n_state     = efsa_pkg::S_CHECK;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            efsa_pkg::S_ALLOC: begin
                n_head     = link_q;
                n_free     = r_free - 1'b1;
                n_done     = 1'b1;
                n_gslot    = r_idx;
                n_res_off  = r_offset;
                n_res_free = r_free - 1'b1;
                n_state    = efsa_pkg::S_IDLE;
            end
            efsa_pkg::S_CHECK: begin
                // The entry of slot r_idx is on the read port; r_cnt slots
                // are marked so far.
                if (link_mark) begin
                    // The slot was reached before: the list loops.
                    n_chk_sts   = efsa_pkg::STS_CORRUPT;
                    link_req.rd = 1'b1;
                    n_idx       = r_head;
                    n_state     = efsa_pkg::S_UNDO;
                end else begin
                    link_req.wr    = 1'b1;
                    link_req.wdata = link_q;
                    link_req.wmark = 1'b1;
                    n_cnt          = r_cnt + 1'b1;
                    if (walk_last || !link_in_pool || link_q == r_idx) begin
                        // A link back to the slot being marked is a loop; it is
                        // caught here rather than by the read below.
                        n_chk_sts   = walk_last ? efsa_pkg::STS_OK
                                                : efsa_pkg::STS_CORRUPT;
                        link_req.rd = 1'b1;
                        n_idx       = r_head;
                        n_state     = efsa_pkg::S_UNDO;
                    end else begin
                        link_req.rd    = 1'b1;
                        link_req.raddr = link_q;
                        n_idx          = link_q;
                    end
                end
            end
            efsa_pkg::S_UNDO: begin
                // Walk the marked slots again from the head, clearing each
                // mark; r_cnt slots are still marked.
                link_req.wr    = 1'b1;
                link_req.wdata = link_q;
                if (r_cnt <= efsa_pkg::t_slot'(1)) begin
                    n_done   = 1'b1;
                    n_status = r_chk_sts;
                    n_state  = efsa_pkg::S_IDLE;
                end else begin
                    link_req.rd    = 1'b1;
                    link_req.raddr = link_q;
                    n_idx          = link_q;
                    n_cnt          = r_cnt - 1'b1;
                end
            end
            default: begin
                n_state = efsa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= efsa_pkg::S_IDLE;
            r_head     <= '0;
            r_free     <= efsa_pkg::t_slot'(efsa_pkg::SLOTS);
            r_cnt      <= '0;
            r_obj_size <= efsa_pkg::OBJ_W'(1);
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_free  <= n_free;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_obj_size <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_offset   <= n_offset;
        r_chk_sts  <= n_chk_sts;
        r_status   <= n_status;
        r_gslot    <= n_gslot;
        r_res_off  <= n_res_off;
        r_res_free <= n_res_free;
    end

    assign busy           = (r_state != efsa_pkg::S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_granted_slot = r_gslot;
    assign o_byte_offset  = r_res_off;
    assign o_free_count   = r_res_free;

endmodule

/* src/efsa_checker.sv */
// ----------------------------------------------------------------------------
// efsa_checker
// Port-level checks of the slot allocator, bound to its top level.
// ----------------------------------------------------------------------------
module efsa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_op,
    input logic [7:0]  i_slot,
    input logic        i_cfg_we,
    input logic [15:0] i_cfg_wdata,
    input logic        o_done,
    input logic [2:0]  o_status,
    input logic [7:0]  o_granted_slot,
    input logic [23:0] o_byte_offset,
    input logic [7:0]  o_free_count
);

    // Reset leaves the block idle with no result showing.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_done))
        else $error("block not idle after reset");

    // An accepted item either shows its result next cycle or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_done || busy))
        else $error("accepted item produced neither result nor busy");

    // The block only leaves its busy phase by showing a result.
    a_busy_ends_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_done)
        else $error("busy dropped without a result");

    // Only a successful allocate carries a slot or an offset.
    a_grant_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != efsa_pkg::STS_OK) |->
            (o_granted_slot == '0 && o_byte_offset == '0))
        else $error("failed item carries a grant");

endmodule

bind embedded_free_list_slot_allocator_top efsa_checker u_efsa_checker (.*);
